FILE: rtl/core/hdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the header/terminator deframer.
package hdt_pkg;

    localparam int unsigned POS_W       = 11;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned LEN_W       = 11;
    localparam int unsigned IDX_W       = 2;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(1024);
    localparam logic [POS_W:0]   MARK_BYTES  = (POS_W+1)'(4);

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_GOOD  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [IDX_W-1:0] REG_HEADER     = 2'd0;
    localparam logic [IDX_W-1:0] REG_TERMINATOR = 2'd1;
    localparam logic [IDX_W-1:0] REG_PAYLOAD_LEN = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
    } out_t;

    typedef struct packed {
        logic [WORD_W-1:0] header_word;
        logic [WORD_W-1:0] terminator_word;
        logic [LEN_W-1:0]  payload_len;
    } cfg_t;

    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

endpackage

FILE: rtl/core/header_terminator_deframer.sv
`timescale 1ns / 1ps
// Top level of the header/terminator deframer.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   item   (op, rx_byte)
//  result    out        result_valid / result_stall result (kind, payload_byte)
//  cfg       in         cfg_we                    cfg_index, cfg_data
//
// One beat per cycle unless item_stall; each result is registered, via skid if stalled.
// The parser state update is one short pass between item accept and result register.
// Result register plus skid: item_stall rises the cycle after a result arrives while
// one is stalled, and drops the cycle after result_stall goes low.
// Reset: header phase, position zero, header and terminator zero, length one.
module header_terminator_deframer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  hdt_pkg::in_t                item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output hdt_pkg::out_t               result,
    input  logic                        cfg_we,
    input  logic [hdt_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hdt_pkg::WORD_W-1:0]  cfg_data
);
    import hdt_pkg::*;

    cfg_t  cfg_reg;
    res_t  res;
    logic  take;
    logic  out_valid_reg;
    out_t  out_data_reg;
    logic  skid_valid_reg;
    out_t  skid_data_reg;
    logic  drain;

    assign item_stall   = skid_valid_reg;
    assign take         = item_valid && !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign drain        = !out_valid_reg || !result_stall;

    hdt_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .beat  (item),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word     <= '0;
            cfg_reg.terminator_word <= '0;
            cfg_reg.payload_len     <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER:      cfg_reg.header_word     <= cfg_data;
                REG_TERMINATOR:  cfg_reg.terminator_word <= cfg_data;
                REG_PAYLOAD_LEN: cfg_reg.payload_len     <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res.valid;
            end
        end
        else if (res.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res.data;
        end
        else if (res.valid)
        begin
            skid_data_reg <= res.data;
        end
    end

endmodule

FILE: rtl/core/hdt_parser.sv
`timescale 1ns / 1ps
// Frame parser: header match, payload pass-through, terminator match.
module hdt_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  hdt_pkg::in_t beat,
    input  hdt_pkg::cfg_t cfg,
    output hdt_pkg::res_t res
);
    import hdt_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TERM    = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W:0]   pos_inc;
    logic [LEN_W-1:0] len_eff;
    logic [7:0]       hdr_byte;
    logic [7:0]       term_byte;

    assign pos_inc   = {1'b0, position_reg} + (POS_W+1)'(1);
    assign len_eff   = (cfg.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg.payload_len;
    assign hdr_byte  = 8'(cfg.header_word >> {position_reg[1:0], 3'b000});
    assign term_byte = 8'(cfg.terminator_word >> {position_reg[1:0], 3'b000});

    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg;
        res           = '0;
        if (beat.op == OP_TIMEOUT)
        begin
            phase_next    = PH_HEADER;
            position_next = '0;
            res.valid     = 1'b1;
            res.data.kind = KIND_ERROR;
        end
        else
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    res.valid             = 1'b1;
                    res.data.kind         = KIND_DATA;
                    res.data.payload_byte = beat.rx_byte;
                    if (pos_inc >= {1'b0, len_eff})
                    begin
                        phase_next    = PH_TERM;
                        position_next = '0;
                    end
                    else
                    begin
                        position_next = pos_inc[POS_W-1:0];
                    end
                end
                PH_TERM:
                begin
                    if (beat.rx_byte != term_byte)
                    begin
                        phase_next    = PH_HEADER;
                        position_next = '0;
                        res.valid     = 1'b1;
                        res.data.kind = KIND_ERROR;
                    end
                    else if (pos_inc >= MARK_BYTES)
                    begin
                        phase_next    = PH_HEADER;
                        position_next = '0;
                        res.valid     = 1'b1;
                        res.data.kind = KIND_GOOD;
                    end
                    else
                    begin
                        position_next = pos_inc[POS_W-1:0];
                    end
                end
                PH_HEADER:
                begin
                    if (beat.rx_byte != hdr_byte)
                    begin
                        position_next = '0;
                        res.valid     = 1'b1;
                        res.data.kind = KIND_ERROR;
                    end
                    else if (pos_inc >= MARK_BYTES)
                    begin
                        position_next = '0;
                        phase_next    = (len_eff == '0) ? PH_TERM : PH_PAYLOAD;
                    end
                    else
                    begin
                        position_next = pos_inc[POS_W-1:0];
                    end
                end
                default:
                begin
                    phase_next    = PH_HEADER;
                    position_next = '0;
                end
            endcase
        end
        if (!take)
        begin
            phase_next    = phase_reg;
            position_next = position_reg;
            res.valid     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            position_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
        end
    end

endmodule

FILE: rtl/core/hdt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the deframer, bound to the top level.
module hdt_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_stall,
    input  logic                        result_valid,
    input  logic                        result_stall,
    input  hdt_pkg::out_t               result
);
    import hdt_pkg::*;

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kind == KIND_DATA || result.kind == KIND_GOOD ||
                          result.kind == KIND_ERROR))
        else $error("illegal result kind");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_DATA |-> result.payload_byte == 8'h00)
        else $error("status beat carries a non-zero byte");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("intake stalled with empty output");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(result_valid && result_stall))
        else $error("intake stall without a stalled result");

endmodule

bind header_terminator_deframer hdt_checker u_hdt_checker (.*);

FILE: test/tb_header_terminator_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the header/terminator deframer: directed and random frames.
module tb_header_terminator_deframer;

    import hdt_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_TERM    = 2'd2;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int unsigned ITEM_BUDGET  = 1150;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 4;

    typedef enum int unsigned {
        FRAME_CLEAN,
        FRAME_BAD_MARK,
        FRAME_TIMEOUT
    } frame_fault_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    in_t                item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    out_t               result;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [WORD_W-1:0]  cfg_data = '0;

    header_terminator_deframer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state and register copy
    logic [WORD_W-1:0]  m_hdr = '0;
    logic [WORD_W-1:0]  m_term = '0;
    logic [LEN_W-1:0]   m_len = LEN_W'(1);
    logic [1:0]         m_phase = PH_HEADER;
    logic [POS_W-1:0]   m_pos = '0;

    // register values as seen by the stimulus
    logic [WORD_W-1:0]  cur_hdr = '0;
    logic [WORD_W-1:0]  cur_term = '0;
    logic [LEN_W-1:0]   cur_len = LEN_W'(1);

    in_t                rx_event_q[$];
    out_t               deframed_q[$];
    out_t               exp_res;

    int unsigned        mismatches = 0;
    int unsigned        sent_events = 0;
    int unsigned        idle_cycles = 0;
    int unsigned        gap_left = 0;
    int unsigned        stall_left = 0;
    bit                 item_taken = 1'b0;
    bit                 result_taken = 1'b0;
    bit                 send_burst = 1'b0;
    bit                 recv_burst = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] word_byte(input logic [WORD_W-1:0] w, input int unsigned idx);
        return w[8*(idx%4) +: 8];
    endfunction

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        mismatches++;
        $display("mismatch in %s at %0t: got %0h, expected %0h", field, $time, got, want);
    endtask

    task automatic deframe_event(input in_t ev);
        logic [LEN_W-1:0] len;
        out_t             res;
        bit               has_res;
        len = (m_len > MAX_PAYLOAD) ? MAX_PAYLOAD : m_len;
        has_res = 1'b1;
        res.kind = KIND_ERROR;
        res.payload_byte = 8'h00;
        if (ev.op == OP_TIMEOUT)
        begin
            m_phase = PH_HEADER;
            m_pos = '0;
        end
        else if (m_phase == PH_PAYLOAD)
        begin
            m_pos = m_pos + 1'b1;
            if (m_pos >= len)
            begin
                m_phase = PH_TERM;
                m_pos = '0;
            end
            res.kind = KIND_DATA;
            res.payload_byte = ev.rx_byte;
        end
        else if (m_phase == PH_TERM)
        begin
            if (ev.rx_byte != word_byte(m_term, 32'(m_pos)))
            begin
                m_phase = PH_HEADER;
                m_pos = '0;
            end
            else
            begin
                m_pos = m_pos + 1'b1;
                if (m_pos >= MARK_BYTES)
                begin
                    m_phase = PH_HEADER;
                    m_pos = '0;
                    res.kind = KIND_GOOD;
                end
                else
                    has_res = 1'b0;
            end
        end
        else
        begin
            m_phase = PH_HEADER;
            if (ev.rx_byte != word_byte(m_hdr, 32'(m_pos)))
                m_pos = '0;
            else
            begin
                has_res = 1'b0;
                m_pos = m_pos + 1'b1;
                if (m_pos >= MARK_BYTES)
                begin
                    m_pos = '0;
                    m_phase = (len == '0) ? PH_TERM : PH_PAYLOAD;
                end
            end
        end
        if (has_res)
            deframed_q.push_back(res);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && !(item_valid && !item_taken))
        begin
            if (gap_left != 0)
            begin
                item_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (rx_event_q.size() != 0)
            begin
                item <= rx_event_q.pop_front();
                item_valid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    send_burst <= !send_burst;
                gap_left <= draw_wait(send_burst);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_burst <= !recv_burst;
                stall_left <= draw_wait(recv_burst);
                result_stall <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                result_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // monitor; a beat taken at a register write still sees the old value
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                deframe_event(item);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEADER:      m_hdr = cfg_data;
                    REG_TERMINATOR:  m_term = cfg_data;
                    REG_PAYLOAD_LEN: m_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (deframed_q.size() == 0)
                    report("unexpected result", {6'd0, result.kind}, 8'h00);
                else
                begin
                    exp_res = deframed_q.pop_front();
                    if (result.kind != exp_res.kind)
                        report("kind", {6'd0, result.kind}, {6'd0, exp_res.kind});
                    if (result.payload_byte != exp_res.payload_byte)
                        report("payload_byte", result.payload_byte, exp_res.payload_byte);
                end
            end
        end
        item_taken <= rst_n && item_valid && !item_stall;
        result_taken <= rst_n && result_valid && !result_stall;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HEADER:      cur_hdr = value;
            REG_TERMINATOR:  cur_term = value;
            REG_PAYLOAD_LEN: cur_len = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (rx_event_q.size() != 0 || item_valid || deframed_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        in_t ev;
        ev.op = OP_BYTE;
        ev.rx_byte = b;
        rx_event_q.push_back(ev);
        sent_events++;
    endtask

    task automatic push_timeout();
        in_t ev;
        ev.op = OP_TIMEOUT;
        ev.rx_byte = 8'($urandom);
        rx_event_q.push_back(ev);
        sent_events++;
    endtask

    task automatic push_mark(input logic [WORD_W-1:0] w, input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_byte(word_byte(w, i));
    endtask

    // a faulty frame stops right after its faulty beat
    task automatic push_frame(input frame_fault_t fault);
        int unsigned plen;
        int unsigned total;
        int unsigned at;
        int unsigned i;
        logic [7:0]  b;
        plen = (cur_len > MAX_PAYLOAD) ? 32'(MAX_PAYLOAD) : 32'(cur_len);
        total = plen + 8;
        at = total;
        if (fault == FRAME_TIMEOUT)
            at = $urandom_range(0, total - 1);
        else if (fault == FRAME_BAD_MARK)
            at = $urandom_range(0, 1) ? $urandom_range(0, 3) : plen + 4 + $urandom_range(0, 3);
        for (i = 0; i < total && i <= at; i++)
        begin
            if (i < 4)
                b = word_byte(cur_hdr, i);
            else if (i < plen + 4)
                b = 8'($urandom);
            else
                b = word_byte(cur_term, i - plen - 4);
            if (i != at)
                push_byte(b);
            else if (fault == FRAME_TIMEOUT)
                push_timeout();
            else
                push_byte(b ^ (8'd1 << $urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        int unsigned  r;
        int unsigned  frames;
        int unsigned  n;
        logic [31:0]  w;
        logic [10:0]  len;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: zero marks, one payload byte
        push_timeout();
        push_frame(FRAME_CLEAN);
        push_byte(8'h01);
        wait_drained();

        // all-ones header, no payload
        set_reg(REG_HEADER, 32'hFFFF_FFFF);
        set_reg(REG_TERMINATOR, 32'h807F_01FE);
        set_reg(REG_PAYLOAD_LEN, 32'd0);
        push_frame(FRAME_CLEAN);
        push_mark(cur_hdr, 4);
        push_timeout();
        wait_drained();

        // timeout in payload, then length shortened mid-frame
        set_reg(REG_PAYLOAD_LEN, 32'd5);
        push_mark(cur_hdr, 4);
        push_byte(8'h00);
        push_timeout();
        push_mark(cur_hdr, 4);
        push_byte(8'hAA);
        push_byte(8'h55);
        push_byte(8'hFF);
        wait_drained();
        set_reg(REG_PAYLOAD_LEN, 32'd2);
        push_byte(8'h3C);
        push_mark(cur_term, 4);
        wait_drained();

        // write to an unused index leaves the registers alone
        set_reg(REG_UNUSED, 32'h1234_5678);
        push_frame(FRAME_CLEAN);
        wait_drained();

        // oversize length saturates
        set_reg(REG_PAYLOAD_LEN, 32'd2047);
        push_frame(FRAME_CLEAN);
        wait_drained();

        do
        begin
            r = $urandom_range(0, 9);
            w = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            set_reg(REG_HEADER, w);
            r = $urandom_range(0, 9);
            w = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            set_reg(REG_TERMINATOR, w);
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 11'd0;
            else if (r < 75)
                len = 11'($urandom_range(1, 8));
            else
                len = 11'($urandom_range(9, 40));
            set_reg(REG_PAYLOAD_LEN, {21'd0, len});
            frames = $urandom_range(3, 8);
            repeat (frames)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 1))
                            push_timeout();
                        else
                            push_byte(8'($urandom));
                    end
                end
                r = $urandom_range(0, 99);
                if (r < 70)
                    push_frame(FRAME_CLEAN);
                else if (r < 85)
                    push_frame(FRAME_BAD_MARK);
                else
                    push_frame(FRAME_TIMEOUT);
            end
            wait_drained();
        end
        while (sent_events < ITEM_BUDGET);

        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/hdt_pkg.sv
rtl/core/hdt_parser.sv
rtl/core/header_terminator_deframer.sv
rtl/core/hdt_checker.sv
test/tb_header_terminator_deframer.sv
